// ===== rtl/fcw_pkg.sv =====
`timescale 1ns / 1ps
package fcw_pkg;

   localparam int TABLE_BYTES = 8192;
   localparam int BANK_DEPTH  = TABLE_BYTES / 2;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 13;
   localparam int BYTE_W    = 8;
   localparam int CLUS_W    = 12;
   localparam int IDX_W     = 14;
   localparam int SPC_W     = 8;
   localparam int LBA_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W    = CLUS_W + SPC_W;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_LOW     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOCHAIN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPC = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LBA = 1'b1;

   localparam logic [SPC_W-1:0]  SPC_RST    = 8'd1;
   localparam logic [LBA_W-1:0]  LBA_RST    = 32'd33;
   localparam logic [CLUS_W-1:0] CLUS_FIRST = 12'd2;
   localparam logic [CLUS_W-1:0] END_MARK   = 12'hFF8;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

// ===== rtl/fcw_req_if.sv =====
`timescale 1ns / 1ps
interface fcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [fcw_pkg::CMD_W-1:0]     cmd;
   logic [fcw_pkg::ADDR_W-1:0]    table_addr;
   logic [fcw_pkg::BYTE_W-1:0]    table_byte;
   logic [fcw_pkg::CLUS_W-1:0]    start_cluster;

   modport source (output valid, cmd, table_addr, table_byte, start_cluster, input ready);
   modport sink   (input valid, cmd, table_addr, table_byte, start_cluster, output ready);
endinterface

// ===== rtl/fcw_rsp_if.sv =====
`timescale 1ns / 1ps
interface fcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcw_pkg::LBA_W-1:0]     sector_addr;
   logic [fcw_pkg::CLUS_W-1:0]    cluster;
   logic [fcw_pkg::CLUS_W-1:0]    next_cluster;
   logic                          last;
   logic [fcw_pkg::STAT_W-1:0]    status;

   modport source (output valid, sector_addr, cluster, next_cluster, last, status, input ready);
   modport sink   (input valid, sector_addr, cluster, next_cluster, last, status, output ready);
endinterface

// ===== rtl/fcw_csr_if.sv =====
`timescale 1ns / 1ps
interface fcw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fcw_pkg::CSR_IDX_W-1:0]    index;
   logic [fcw_pkg::LBA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fat12_cluster_chain_walker_top.sv =====
`timescale 1ns / 1ps
// channel   dir  ports                                               beat
// req_ch    in   cmd, table_addr, table_byte, start_cluster          valid & ready
// rsp_ch    out  sector_addr, cluster, next_cluster, last, status    valid & ready
// csr_ch    in   index (0 sectors/cluster, 1 data start), data       valid & ready
//
// Start or advance reads the two table banks (even and odd bytes) into registers,
// followed by decode and address math into the output register.
// Reset clears chain state and presets registers; table contents stay undefined.
// A finished result waits in the output register; a lookup that finds it
// occupied holds its read data until the register frees.
module fat12_cluster_chain_walker_top (
   input  logic       clock,
   input  logic       reset,
   fcw_req_if.sink    req_ch,
   fcw_rsp_if.source  rsp_ch,
   fcw_csr_if.sink    csr_ch
);
   import fcw_pkg::*;

   logic [BYTE_W-1:0]  even_mem [BANK_DEPTH];
   logic [BYTE_W-1:0]  odd_mem  [BANK_DEPTH];

   state_type          state_ff, state_in;
   logic [CLUS_W-1:0]  cur_ff, cur_in;
   logic               active_ff, active_in;
   logic [SPC_W-1:0]   spc_ff;
   logic [LBA_W-1:0]   lba_ff;
   logic [CLUS_W-1:0]  clus_ff, clus_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;
   logic               idx_odd_ff, lo_ok_ff, hi_ok_ff;
   logic [BYTE_W-1:0]  even_q_ff, odd_q_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LBA_W-1:0]   sec_ff;
   logic [CLUS_W-1:0]  rclus_ff, rnext_ff;
   logic               rlast_ff;
   logic [STAT_W-1:0]  rstat_ff;

   logic               req_ready, req_beat, out_free, rd_en, out_load;
   logic               wr_en;
   logic [IDX_W-1:0]   clus3, idx, idx1;
   logic [BYTE_W-1:0]  lo_byte, hi_byte;
   logic [2*BYTE_W-1:0] word;
   logic [CLUS_W-1:0]  entry, ofs;
   logic [PROD_W-1:0]  prod;
   logic [LBA_W-1:0]   sec;
   logic               is_last;

   assign req_ch.ready = req_ready;
   assign req_beat     = req_ch.valid & req_ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign wr_en = req_beat && (req_ch.cmd == CMD_WRITE) &&
                  ({1'b0, req_ch.table_addr} < IDX_W'(TABLE_BYTES));

   // cluster * 3 / 2 and the byte after it
   assign clus3 = {2'b00, clus_in} + {1'b0, clus_in, 1'b0};
   assign idx   = {1'b0, clus3[IDX_W-1:1]};
   assign idx1  = idx + IDX_W'(1);

   always_comb begin
      clus_in = cur_ff;
      stat_in = STAT_OK;
      unique case (req_ch.cmd)
         CMD_START: begin
            clus_in = req_ch.start_cluster;
            stat_in = (req_ch.start_cluster < CLUS_FIRST) ? STAT_LOW : STAT_OK;
         end
         CMD_NEXT: begin
            if (!active_ff) begin
               clus_in = '0;
               stat_in = STAT_NOCHAIN;
            end else begin
               clus_in = cur_ff;
               stat_in = (cur_ff < CLUS_FIRST) ? STAT_LOW : STAT_OK;
            end
         end
         default: begin
            clus_in = cur_ff;
            stat_in = STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && (req_ch.cmd == CMD_START || req_ch.cmd == CMD_NEXT)) begin
               rd_en    = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !req_ch.table_addr[0]) begin
         even_mem[req_ch.table_addr[BANK_AW:1]] <= req_ch.table_byte;
      end
      if (rd_en) begin
         even_q_ff <= even_mem[idx1[BANK_AW:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && req_ch.table_addr[0]) begin
         odd_mem[req_ch.table_addr[BANK_AW:1]] <= req_ch.table_byte;
      end
      if (rd_en) begin
         odd_q_ff <= odd_mem[idx[BANK_AW:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         clus_ff    <= clus_in;
         stat_ff    <= stat_in;
         idx_odd_ff <= idx[0];
         lo_ok_ff   <= idx < IDX_W'(TABLE_BYTES);
         hi_ok_ff   <= idx1 < IDX_W'(TABLE_BYTES);
      end
   end

   // decode entry and first sector
   assign lo_byte = lo_ok_ff ? (idx_odd_ff ? odd_q_ff : even_q_ff) : '0;
   assign hi_byte = hi_ok_ff ? (idx_odd_ff ? even_q_ff : odd_q_ff) : '0;
   assign word    = {hi_byte, lo_byte};
   assign entry   = clus_ff[0] ? word[2*BYTE_W-1:4] : word[CLUS_W-1:0];
   assign is_last = entry >= END_MARK;
   assign ofs     = clus_ff - CLUS_FIRST;
   assign prod    = PROD_W'(ofs) * PROD_W'(spc_ff);
   assign sec     = lba_ff + LBA_W'(prod);

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      if (out_load) begin
         unique case (stat_ff)
            STAT_OK: begin
               cur_in    = entry;
               active_in = ~is_last;
            end
            STAT_LOW: active_in = 1'b0;
            default: active_in = active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         active_ff <= 1'b0;
         spc_ff    <= SPC_RST;
         lba_ff    <= LBA_RST;
      end else begin
         cur_ff    <= cur_in;
         active_ff <= active_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_SPC: spc_ff <= csr_ch.data[SPC_W-1:0];
               CSR_LBA: lba_ff <= csr_ch.data;
               default: lba_ff <= lba_ff;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rclus_ff <= clus_ff;
         rstat_ff <= stat_ff;
         if (stat_ff == STAT_OK) begin
            sec_ff   <= sec;
            rnext_ff <= entry;
            rlast_ff <= is_last;
         end else begin
            sec_ff   <= '0;
            rnext_ff <= '0;
            rlast_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sector_addr  = sec_ff;
   assign rsp_ch.cluster      = rclus_ff;
   assign rsp_ch.next_cluster = rnext_ff;
   assign rsp_ch.last         = rlast_ff;
   assign rsp_ch.status       = rstat_ff;

   a_lookup_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("lookup did not retire into output register");

   a_lookup_start: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_ch.cmd == CMD_START || req_ch.cmd == CMD_NEXT))
      |=> state_ff == ST_LOOKUP)
      else $error("start or advance beat did not begin a lookup");

   a_write_stays: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_ch.cmd == CMD_WRITE) |=> (state_ff == ST_IDLE && !$rose(rsp_valid_ff)))
      else $error("table write produced a result");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rlast_ff) |-> (rstat_ff == STAT_OK && !active_ff))
      else $error("last set on error status or chain left active");

   a_nochain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rstat_ff == STAT_NOCHAIN) |-> (rclus_ff == '0 && sec_ff == '0))
      else $error("advance without chain carries nonzero fields");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import fcw_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_GOAL   = 1400;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int CFG_EVERY   = 300;

   typedef struct packed {
      logic [LBA_W-1:0]  sector_addr;
      logic [CLUS_W-1:0] cluster;
      logic [CLUS_W-1:0] next_cluster;
      logic              last;
      logic [STAT_W-1:0] status;
   } walk_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcw_req_if req_ch ();
   fcw_rsp_if rsp_ch ();
   fcw_csr_if csr_ch ();

   fat12_cluster_chain_walker_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // mirror of the block's table, chain state and registers
   logic [BYTE_W-1:0] fat_bytes [TABLE_BYTES];
   bit                byte_valid [TABLE_BYTES];
   logic [CLUS_W-1:0] cur_clus = '0;
   bit                chain_on = 1'b0;
   logic [SPC_W-1:0]  spc = SPC_RST;
   logic [LBA_W-1:0]  lba = LBA_RST;

   walk_result_type walk_q [$];

   int  err_count    = 0;
   int  items_sent   = 0;
   int  results_seen = 0;
   int  chains_done  = 0;
   int  cfg_count    = 0;
   int  cycle_count  = 0;
   int  rsp_hold     = 0;
   bit  req_up       = 1'b0;
   bit  req_idle_en  = 1'b1;
   bit  rsp_stall_en = 1'b1;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count, walk_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want_v);
      $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want_v, results_seen);
      err_count++;
   endtask

   function automatic logic [CLUS_W-1:0] fat_entry(input logic [CLUS_W-1:0] c);
      int          idx;
      logic [15:0] word;
      idx  = (int'(c) * 3) / 2;
      word = {fat_bytes[idx+1], fat_bytes[idx]};
      if (c[0])
         return word[15:4];
      return word[11:0];
   endfunction

   function automatic walk_result_type visit_cluster(input logic [CLUS_W-1:0] c);
      walk_result_type r;
      r         = '0;
      r.cluster = c;
      if (c < CLUS_FIRST) begin
         chain_on = 1'b0;
         r.status = STAT_LOW;
      end else begin
         r.sector_addr  = lba + (32'(c) - 32'd2) * 32'(spc);
         r.next_cluster = fat_entry(c);
         r.last         = (r.next_cluster >= END_MARK);
         r.status       = STAT_OK;
         cur_clus       = r.next_cluster;
         chain_on       = !r.last;
      end
      return r;
   endfunction

   function automatic void apply_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                      input logic [BYTE_W-1:0] data,
                                      input logic [CLUS_W-1:0] clus);
      walk_result_type r;
      case (op)
         CMD_WRITE: begin
            fat_bytes[addr]  = data;
            byte_valid[addr] = 1'b1;
         end
         CMD_START: walk_q.push_back(visit_cluster(clus));
         CMD_NEXT: begin
            if (!chain_on) begin
               r        = '0;
               r.status = STAT_NOCHAIN;
               walk_q.push_back(r);
            end else begin
               walk_q.push_back(visit_cluster(cur_clus));
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      walk_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (walk_q.size() == 0) begin
               report("unexpected beat, cluster", 32'(rsp_ch.cluster), 32'd0);
            end else begin
               want = walk_q.pop_front();
               if (rsp_ch.sector_addr !== want.sector_addr)
                  report("sector_addr", rsp_ch.sector_addr, want.sector_addr);
               if (rsp_ch.cluster !== want.cluster)
                  report("cluster", 32'(rsp_ch.cluster), 32'(want.cluster));
               if (rsp_ch.next_cluster !== want.next_cluster)
                  report("next_cluster", 32'(rsp_ch.next_cluster), 32'(want.next_cluster));
               if (rsp_ch.last !== want.last)
                  report("last", 32'(rsp_ch.last), 32'(want.last));
               if (rsp_ch.status !== want.status)
                  report("status", 32'(rsp_ch.status), 32'(want.status));
            end
            rsp_hold = rsp_stall_en ? int'($urandom_range(0, 5)) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data, input logic [CLUS_W-1:0] clus);
      int gap;
      gap = req_idle_en ? int'($urandom_range(0, 5)) : 0;
      if (gap > 0) begin
         if (req_up)
            req_ch.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (!req_up)
         req_ch.valid <= 1'b1;
      req_up = 1'b1;
      req_ch.cmd           <= op;
      req_ch.table_addr    <= addr;
      req_ch.table_byte    <= data;
      req_ch.start_cluster <= clus;
      do @(posedge clock); while (!req_ch.ready);
      apply_item(op, addr, data, clus);
      if (op != CMD_UNUSED)
         items_sent++;
   endtask

   task automatic quiesce();
      if (req_up)
         req_ch.valid <= 1'b0;
      req_up = 1'b0;
      while (walk_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] spc_word, input logic [LBA_W-1:0] lba_word);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_SPC;
      csr_ch.data  <= spc_word;
      do @(posedge clock); while (!csr_ch.ready);
      spc = spc_word[SPC_W-1:0];
      csr_ch.index <= CSR_LBA;
      csr_ch.data  <= lba_word;
      do @(posedge clock); while (!csr_ch.ready);
      lba = lba_word;
      csr_ch.valid <= 1'b0;
      cfg_count++;
   endtask

   task automatic put_byte(input int addr, input logic [BYTE_W-1:0] data);
      send_item(CMD_WRITE, ADDR_W'(addr), data, CLUS_W'($urandom));
   endtask

   // keep the nibble that belongs to the neighboring cluster
   task automatic set_entry(input logic [CLUS_W-1:0] c, input logic [CLUS_W-1:0] e);
      int                idx;
      logic [BYTE_W-1:0] lo, hi;
      idx = (int'(c) * 3) / 2;
      lo  = byte_valid[idx]   ? fat_bytes[idx]   : BYTE_W'($urandom);
      hi  = byte_valid[idx+1] ? fat_bytes[idx+1] : BYTE_W'($urandom);
      if (!c[0]) begin
         lo      = e[7:0];
         hi[3:0] = e[11:8];
      end else begin
         lo[7:4] = e[3:0];
         hi      = e[11:4];
      end
      put_byte(idx, lo);
      put_byte(idx + 1, hi);
   endtask

   task automatic ensure_entry(input logic [CLUS_W-1:0] c);
      int idx;
      idx = (int'(c) * 3) / 2;
      if (c >= CLUS_FIRST && (!byte_valid[idx] || !byte_valid[idx+1]))
         set_entry(c, CLUS_W'($urandom));
   endtask

   task automatic start_at(input logic [CLUS_W-1:0] c);
      ensure_entry(c);
      send_item(CMD_START, ADDR_W'($urandom), BYTE_W'($urandom), c);
   endtask

   task automatic step_chain();
      if (chain_on)
         ensure_entry(cur_clus);
      send_item(CMD_NEXT, ADDR_W'($urandom), BYTE_W'($urandom), CLUS_W'($urandom));
   endtask

   task automatic walk_random_chain();
      logic [CLUS_W-1:0] links [$];
      logic [CLUS_W-1:0] c, tail;
      int                len, steps, pick;
      bit                dup;
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 1)) begin
         c = CLUS_W'($urandom_range(2, 4095 - 2 * len));
         repeat (len) begin
            links.push_back(c);
            c = c + CLUS_W'($urandom_range(1, 2));
         end
      end else begin
         while (links.size() < len) begin
            c   = CLUS_W'($urandom_range(2, 4095));
            dup = 1'b0;
            foreach (links[i])
               if (links[i] == c)
                  dup = 1'b1;
            if (!dup)
               links.push_back(c);
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)
         tail = CLUS_W'($urandom_range(12'hFF8, 12'hFFF));
      else if (pick < 9)
         tail = CLUS_W'($urandom_range(0, 1));
      else
         tail = 12'hFF7;
      for (int i = 0; i < len; i++)
         set_entry(links[i], (i < len - 1) ? links[i+1] : tail);
      start_at(links[0]);
      if ($urandom_range(0, 4) == 0)
         steps = $urandom_range(0, len - 1);
      else
         steps = len - 1 + $urandom_range(0, 2);
      repeat (steps) step_chain();
      chains_done++;
   endtask

   task automatic test_directed();
      step_chain();
      start_at(12'd0);
      start_at(12'd1);
      put_byte(0, 8'h00);
      put_byte(TABLE_BYTES - 1, 8'hFF);
      set_entry(12'd2, 12'hFFF);
      start_at(12'd2);
      step_chain();
      set_entry(12'd3, 12'h004);
      set_entry(12'd4, END_MARK);
      start_at(12'd3);
      step_chain();
      set_entry(12'd4095, 12'hFF7);
      set_entry(12'hFF7, 12'h001);
      start_at(12'd4095);
      repeat (3) step_chain();
      set_entry(12'd5, 12'h000);
      start_at(12'd5);
      step_chain();
      send_item(CMD_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom), CLUS_W'($urandom));
   endtask

   task automatic test_config_settings();
      logic [31:0]      spc_words [5];
      logic [LBA_W-1:0] lba_words [5];
      spc_words = '{32'd0, 32'd1, 32'd128, 32'd255, 32'($urandom_range(1, 128))};
      lba_words = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FF00, $urandom};
      for (int i = 0; i < 5; i++) begin
         quiesce();
         configure({$urandom} & 32'hFFFF_FF00 | spc_words[i], lba_words[i]);
         repeat (4) walk_random_chain();
      end
   endtask

   task automatic test_paused_stream();
      req_idle_en  = 1'b0;
      rsp_stall_en = 1'b1;
      repeat (3) begin
         repeat (3) walk_random_chain();
         quiesce();
      end
      rsp_stall_en = 1'b0;
      repeat (4) walk_random_chain();
      req_idle_en  = 1'b1;
      rsp_stall_en = 1'b1;
   endtask

   task automatic test_random_chains();
      int pick, next_cfg;
      next_cfg = items_sent + CFG_EVERY;
      while (items_sent < ITEM_GOAL) begin
         if (items_sent >= next_cfg) begin
            quiesce();
            configure($urandom, $urandom);
            next_cfg += CFG_EVERY;
         end
         if (chains_done % 12 == 0) begin
            req_idle_en  = ($urandom_range(0, 3) != 0);
            rsp_stall_en = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70)
            walk_random_chain();
         else if (pick < 80)
            put_byte($urandom_range(0, TABLE_BYTES - 1), BYTE_W'($urandom));
         else if (pick < 85)
            send_item(CMD_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom), CLUS_W'($urandom));
         else if (pick < 90)
            start_at(CLUS_W'($urandom_range(0, 1)));
         else if (pick < 95)
            step_chain();
         else
            start_at(CLUS_W'($urandom));
      end
   endtask

   initial begin
      req_ch.valid         <= 1'b0;
      req_ch.cmd           <= CMD_WRITE;
      req_ch.table_addr    <= '0;
      req_ch.table_byte    <= '0;
      req_ch.start_cluster <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_SPC;
      csr_ch.data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_settings();
      test_paused_stream();
      test_random_chains();
      quiesce();
      $display("Sent %0d table and lookup beats, checked %0d results over %0d chains",
               items_sent, results_seen, chains_done);
      $display("Applied %0d register settings including sector and base extremes", cfg_count);
      if (err_count == 0 && walk_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fcw_pkg.sv
rtl/fcw_req_if.sv
rtl/fcw_rsp_if.sv
rtl/fcw_csr_if.sv
rtl/fat12_cluster_chain_walker_top.sv
tb/tb_top.sv
